// File: rtl/pcx_rle_planar_writer_macros.svh
// Assertion macros for the PCX run-length planar writer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PCX_RLE_PLANAR_WRITER_MACROS_SVH
`define PCX_RLE_PLANAR_WRITER_MACROS_SVH

// Clocked property, disabled while reset is held.
`define PCXRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define PCXRLE_ASSERT_NEVER(lbl, cond, msg) \
  `PCXRLE_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/pcxrle_pkg.sv
// Shared constants, register codes and control structs for the PCX
// run-length planar writer. No dependencies.
package pcxrle_pkg;

  localparam int unsigned RowStride  = 80;
  localparam int unsigned PlaneCount = 4;

  localparam int unsigned BplW     = 7;
  localparam int unsigned RowW     = 9;
  localparam int unsigned CntW     = 6;
  localparam int unsigned PlaneW   = 2;
  localparam int unsigned OffW     = 16;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [1:0]      RunTag       = 2'b11;
  localparam logic [BplW-1:0] BplReset     = BplW'(80);
  localparam logic [RowW-1:0] FirstRowRst  = RowW'(0);
  localparam logic [RowW-1:0] LastRowRst   = RowW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BPL       = 2'd0,
    CFG_FIRST_ROW = 2'd1,
    CFG_LAST_ROW  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic take;      // accept the input word
    logic emit_one;  // issue one write into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_emit;  // accepting the input word starts a write burst
    logic slot_free;   // output register can take a word this cycle
    logic last_one;    // the write issued now ends the burst
  } dp_status_t;

endpackage

// File: rtl/pcx_rle_planar_writer.sv
// Top level of the PCX run-length planar writer: controller plus datapath.
// Depends on pcxrle_pkg, pcxrle_ctrl, pcxrle_dp and the assertion macros.
//
//   channel   dir  handshake                  payload
//   s_axis    in   tvalid / tready            tdata[7:0] data_byte
//   m_axis    out  tvalid / tready            tdata, tlast last_write, tuser image_done
//   cfg       in   cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// A literal byte is first accepted, then loaded into the output register.
// A run is a count byte, then a data byte that is accepted and written N times,
// one write per cycle from the single output register while the output is not stalled (N up to 63).
// Input is held off (s_axis_tready low) while a burst is being written.
// Output backpressure stalls the burst; the last word may wait while a new byte is taken.
// Reset is asynchronous, active low; no clearing pass.
`include "pcx_rle_planar_writer_macros.svh"

module pcx_rle_planar_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcxrle_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pcxrle_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] write_offset, [19:16] plane_mask, [27:20] pixel_byte, [31:28] zero
  output logic [31:0]                       m_axis_tdata,
  output logic                              m_axis_tlast,  // last_write
  output logic                              m_axis_tuser   // [0] image_done
);

  pcxrle_pkg::ctrl_cmd_t              cmd;
  pcxrle_pkg::dp_status_t             status;
  logic [pcxrle_pkg::OffW-1:0]        out_offset;
  logic [pcxrle_pkg::MaskW-1:0]       out_mask;
  logic [pcxrle_pkg::ByteW-1:0]       out_pixel;

  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcxrle_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_offset_o (out_offset),
    .out_mask_o   (out_mask),
    .out_pixel_o  (out_pixel),
    .out_last_o   (m_axis_tlast),
    .out_done_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, out_pixel, out_mask, out_offset};

  `PCXRLE_ASSERT(a_mask_onehot, m_axis_tvalid |-> $onehot(m_axis_tdata[19:16]), "plane mask not one-hot")
  `PCXRLE_ASSERT_NEVER(a_no_take_in_burst, s_axis_tready && cmd.emit_one, "write issued while accepting input")
  `PCXRLE_ASSERT(a_emit_slot, cmd.emit_one |-> (!m_axis_tvalid || m_axis_tready), "output word overwritten")
  `PCXRLE_ASSERT(a_done_is_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "image done on non-final write")

endmodule

// File: rtl/pcxrle_ctrl.sv
// Controller for the PCX run-length planar writer: accepts words and
// sequences write bursts. Depends on pcxrle_pkg.
module pcxrle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pcxrle_pkg::dp_status_t status_i,
  output pcxrle_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.take     = in_valid_i;
      ST_EMIT: cmd_o.emit_one = status_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && status_i.start_emit) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status_i.slot_free && status_i.last_one) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/pcxrle_dp.sv
// Datapath for the PCX run-length planar writer: configuration registers,
// decode state, write position and the output register. Depends on pcxrle_pkg.
module pcxrle_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [pcxrle_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [pcxrle_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic [pcxrle_pkg::ByteW-1:0]            in_byte_i,
  input  pcxrle_pkg::ctrl_cmd_t                   cmd_i,
  output pcxrle_pkg::dp_status_t                  status_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [pcxrle_pkg::OffW-1:0]             out_offset_o,
  output logic [pcxrle_pkg::MaskW-1:0]            out_mask_o,
  output logic [pcxrle_pkg::ByteW-1:0]            out_pixel_o,
  output logic                                    out_last_o,
  output logic                                    out_done_o
);

  logic [pcxrle_pkg::BplW-1:0]   bpl_q;
  logic [pcxrle_pkg::RowW-1:0]   first_row_q;
  logic [pcxrle_pkg::RowW-1:0]   last_row_q;
  logic                          pend_q;
  logic [pcxrle_pkg::CntW-1:0]   run_len_q;
  logic [pcxrle_pkg::BplW-1:0]   line_off_q;
  logic [pcxrle_pkg::PlaneW-1:0] plane_q;
  logic [pcxrle_pkg::RowW-1:0]   row_q;
  logic                          fin_q;
  logic [pcxrle_pkg::CntW-1:0]   cnt_q;
  logic [pcxrle_pkg::ByteW-1:0]  byte_q;
  logic                          out_valid_q;

  logic [pcxrle_pkg::OffW-1:0]   out_offset_q;
  logic [pcxrle_pkg::MaskW-1:0]  out_mask_q;
  logic [pcxrle_pkg::ByteW-1:0]  out_pixel_q;
  logic                          out_last_q;
  logic                          out_done_q;

  logic                          cfg_hit;
  logic [pcxrle_pkg::RowW-1:0]   restart_row;
  logic [pcxrle_pkg::BplW-1:0]   line_len;
  logic [pcxrle_pkg::BplW-1:0]   line_off_inc;
  logic                          line_end;
  logic                          plane_end;
  logic [pcxrle_pkg::RowW-1:0]   row_inc;
  logic                          done;
  logic                          is_run;
  logic [pcxrle_pkg::OffW-1:0]   offset;

  always_comb begin
    cfg_hit     = 1'b0;
    restart_row = first_row_q;
    unique case (pcxrle_pkg::cfg_idx_e'(cfg_idx_i))
      pcxrle_pkg::CFG_BPL:       cfg_hit = cfg_we_i;
      pcxrle_pkg::CFG_FIRST_ROW: begin
        cfg_hit     = cfg_we_i;
        restart_row = cfg_data_i[pcxrle_pkg::RowW-1:0];
      end
      pcxrle_pkg::CFG_LAST_ROW:  cfg_hit = cfg_we_i;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (bpl_q == '0) begin
      line_len = pcxrle_pkg::BplW'(1);
    end else if (bpl_q > pcxrle_pkg::BplW'(pcxrle_pkg::RowStride)) begin
      line_len = pcxrle_pkg::BplW'(pcxrle_pkg::RowStride);
    end else begin
      line_len = bpl_q;
    end
  end

  assign line_off_inc = line_off_q + pcxrle_pkg::BplW'(1);
  assign line_end     = (line_off_inc >= line_len);
  assign plane_end    = (plane_q == pcxrle_pkg::PlaneW'(pcxrle_pkg::PlaneCount - 1));
  assign row_inc      = row_q + pcxrle_pkg::RowW'(1);
  assign done         = line_end && plane_end && (row_inc >= last_row_q);
  assign is_run       = (in_byte_i[7:6] == pcxrle_pkg::RunTag);
  assign offset       = pcxrle_pkg::OffW'(row_q) * pcxrle_pkg::OffW'(pcxrle_pkg::RowStride)
                      + pcxrle_pkg::OffW'(line_off_q);

  assign status_o.start_emit = !fin_q && (row_q < last_row_q) &&
                               (pend_q ? (run_len_q != '0) : !is_run);
  assign status_o.slot_free  = !out_valid_q || out_ready_i;
  assign status_o.last_one   = (cnt_q == pcxrle_pkg::CntW'(1)) || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q       <= pcxrle_pkg::BplReset;
      first_row_q <= pcxrle_pkg::FirstRowRst;
      last_row_q  <= pcxrle_pkg::LastRowRst;
      pend_q      <= 1'b0;
      run_len_q   <= '0;
      line_off_q  <= '0;
      plane_q     <= '0;
      row_q       <= pcxrle_pkg::FirstRowRst;
      fin_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_one) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_hit) begin
        unique case (pcxrle_pkg::cfg_idx_e'(cfg_idx_i))
          pcxrle_pkg::CFG_BPL:       bpl_q       <= cfg_data_i[pcxrle_pkg::BplW-1:0];
          pcxrle_pkg::CFG_FIRST_ROW: first_row_q <= cfg_data_i[pcxrle_pkg::RowW-1:0];
          pcxrle_pkg::CFG_LAST_ROW:  last_row_q  <= cfg_data_i[pcxrle_pkg::RowW-1:0];
          default: ;
        endcase
        pend_q     <= 1'b0;
        run_len_q  <= '0;
        line_off_q <= '0;
        plane_q    <= '0;
        row_q      <= restart_row;
        fin_q      <= 1'b0;
      end else if (cmd_i.take) begin
        if (fin_q) begin
          // finished image: word dropped
        end else if (row_q >= last_row_q) begin
          fin_q     <= 1'b1;
          pend_q    <= 1'b0;
          run_len_q <= '0;
        end else if (pend_q) begin
          cnt_q     <= run_len_q;
          pend_q    <= 1'b0;
          run_len_q <= '0;
        end else if (is_run) begin
          pend_q    <= 1'b1;
          run_len_q <= in_byte_i[pcxrle_pkg::CntW-1:0];
        end else begin
          cnt_q <= pcxrle_pkg::CntW'(1);
        end
      end else if (cmd_i.emit_one) begin
        cnt_q <= cnt_q - pcxrle_pkg::CntW'(1);
        if (line_end) begin
          line_off_q <= '0;
          if (plane_end) begin
            plane_q <= '0;
            row_q   <= row_inc;
            if (row_inc >= last_row_q) fin_q <= 1'b1;
          end else begin
            plane_q <= plane_q + pcxrle_pkg::PlaneW'(1);
          end
        end else begin
          line_off_q <= line_off_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) byte_q <= in_byte_i;
    if (cmd_i.emit_one) begin
      out_offset_q <= offset;
      out_mask_q   <= pcxrle_pkg::MaskW'(1) << plane_q;
      out_pixel_q  <= byte_q;
      out_last_q   <= status_o.last_one;
      out_done_q   <= done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_offset_o = out_offset_q;
  assign out_mask_o   = out_mask_q;
  assign out_pixel_o  = out_pixel_q;
  assign out_last_o   = out_last_q;
  assign out_done_o   = out_done_q;

endmodule
